[rtl/atr_pkg.sv]
// Constants, types and helpers shared by the transfer response pipeline.
package atr_pkg;

	localparam int NUM_REGS   = 8;
	localparam int COEF_SLOTS = 4;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int DIV_STEPS  = 32;

	localparam logic signed [63:0] WSAT   = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0]        POS_FS = 32'h7FFF_FFFF;
	localparam logic [31:0]        NEG_FS = 32'h8000_0000;

	// operand pairs of the six cross products: nr, ni, dr, di are slots 0 to 3
	localparam int PROD_A [6] = '{0, 1, 1, 0, 2, 3};
	localparam int PROD_B [6] = '{2, 3, 2, 3, 2, 3};

	typedef struct packed {
		logic       dz;
		logic [1:0] nneg;
		logic [1:0] neg;
		logic [1:0] ovf;
	} flag_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic signed [32:0] e;
		e = {v[31], v};
		return v[31] ? 32'(-e) : 32'(e);
	endfunction

	function automatic logic signed [63:0] sat_w(input logic signed [63:0] s);
		logic signed [63:0] r;
		r = s;
		if (s > WSAT)
			r = WSAT;
		else if (s < -WSAT)
			r = -WSAT;
		return r;
	endfunction

endpackage

[rtl/atr_in_if.sv]
// Input channel carrying one angular frequency per transfer.
interface atr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] omega;

	modport source (output valid, output omega, input ready);
	modport sink (input valid, input omega, output ready);
endinterface

[rtl/atr_out_if.sv]
// Output channel carrying one complex response per transfer.
interface atr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] response_real;
	logic signed [31:0] response_imag;
	logic               divide_by_zero;

	modport source (output valid, output response_real, output response_imag,
		output divide_by_zero, input ready);
	modport sink (input valid, input response_real, input response_imag,
		input divide_by_zero, output ready);
endinterface

[rtl/analog_transfer_response.sv]
// Pipelined evaluator of H(j*omega) = N(j*omega) / D(j*omega) in Q16.16.
//
//  channel  | kind       | payload
//  ---------+------------+----------------------------------------------
//  freq     | valid/ready| omega
//  resp     | valid/ready| response_real, response_imag, divide_by_zero
//  cfg      | write only | cfg_wr_en, cfg_index, cfg_data
//
//  One transfer per cycle in and out while resp is not stalled.
//  Stages: 14 for polynomial evaluation and cross products, one divider set-up,
//  32 restoring divider steps of one quotient bit each, one output register.
//  A stall at resp freezes every stage at once; freq.ready follows it.
//  Reset clears valid bits and loads the coefficient registers.
module analog_transfer_response
	import atr_pkg::*;
#(
	parameter int COEFS_PER_POLY = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	atr_in_if.sink               freq,
	atr_out_if.source            resp,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int DIV0 = 15;
	localparam int LAST = DIV0 + DIV_STEPS + 1;

	logic signed [31:0] cfg_q [NUM_REGS];
	logic [31:0]        cm [2][COEF_SLOTS];
	logic               cs [2][COEF_SLOTS];
	logic signed [31:0] c0v [2];
	logic [LAST:1]      vld_s;
	logic               en;

	logic [31:0] wm_s1, wm_s2, wm_s3;
	logic        wn_s1, wn_s2, wn_s3, wn_s4, wn_s5, wn_s6, wn_s7;
	logic [63:0] ww_s2;
	logic [63:0] cw1_s2 [2];
	logic [46:0] w2_s3;
	logic [46:0] c1w_s3 [2], c1w_s4 [2], c1w_s5 [2], c1w_s6 [2], c1w_s7 [2];
	logic [63:0] w3l_s4;
	logic [46:0] w3h_s4;
	logic [63:0] c2l_s4 [2];
	logic [46:0] c2h_s4 [2];
	logic [61:0] w3_s5;
	logic [61:0] c2w2_s5 [2];
	logic signed [63:0] re_s6 [2], re_s7 [2], re_s8 [2], im_s8 [2];
	logic [63:0] c3l_s6 [2];
	logic [61:0] c3h_s6 [2];
	logic [61:0] c3w3_s7 [2];
	logic [61:0] pm_s9 [4];
	logic [3:0]  pn_s9;
	flag_t       fl_s9, fl_s10, fl_s11, fl_s12, fl_s13, fl_s14;
	logic [63:0] ll_s10 [6];
	logic [61:0] lh_s10 [6], hl_s10 [6];
	logic [59:0] hh_s10 [6];
	logic [5:0]  pneg_s10, pneg_s11;
	logic [123:0] pr_s11 [6];
	logic signed [125:0] sp_s12 [4];
	logic [124:0] dd_s12, dd_s13, dd_s14;
	logic signed [125:0] nu_s13 [2];
	logic [124:0] nm_s14 [2];

	logic [156:0] dv_rem_s [DIV_STEPS+1][2];
	logic [31:0]  dv_q_s [DIV_STEPS+1][2];
	logic [124:0] dv_dd_s [DIV_STEPS+1];
	flag_t        dv_fl_s [DIV_STEPS+1];

	logic [31:0] out_re_q, out_im_q;
	logic        out_dz_q;

	logic [79:0] w3_sum;
	logic [79:0] c2_sum [2];
	logic [94:0] c3_sum [2];
	logic [61:0] c3_sat [2];
	logic signed [63:0] re_nxt [2], im_nxt [2];
	logic [31:0] res_nxt [2];

	assign en         = !vld_s[LAST] || resp.ready;
	assign freq.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_q[i] <= (i == COEF_SLOTS-1 || i == NUM_REGS-1) ? 32'sh0001_0000 : '0;
		end else if (cfg_wr_en) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			for (int p = 0; p < COEF_SLOTS; p++) begin
				cm[k][p] = (p < COEFS_PER_POLY) ? mag32(cfg_q[k*COEF_SLOTS+COEF_SLOTS-1-p]) : '0;
				cs[k][p] = (p < COEFS_PER_POLY) ? cfg_q[k*COEF_SLOTS+COEF_SLOTS-1-p][31] : 1'b0;
			end
			c0v[k] = cfg_q[k*COEF_SLOTS+COEF_SLOTS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAST-1:1], freq.valid};
	end

	always_comb begin
		w3_sum = {1'b0, w3h_s4, 32'h0} + {16'h0, w3l_s4} + 80'd32768;
		for (int k = 0; k < 2; k++) begin
			c2_sum[k] = {1'b0, c2h_s4[k], 32'h0} + {16'h0, c2l_s4[k]} + 80'd32768;
			c3_sum[k] = {1'b0, c3h_s6[k], 32'h0} + {31'h0, c3l_s6[k]} + 95'd32768;
			c3_sat[k] = (|c3_sum[k][94:78]) ? '1 : c3_sum[k][77:16];
			re_nxt[k] = 64'(signed'(c0v[k]))
				- (cs[k][2] ? -$signed({2'b0, c2w2_s5[k]}) : $signed({2'b0, c2w2_s5[k]}));
			im_nxt[k] = sat_w(
				((cs[k][1] ^ wn_s7) ? -$signed({17'b0, c1w_s7[k]}) : $signed({17'b0, c1w_s7[k]}))
				- ((cs[k][3] ^ wn_s7) ? -$signed({2'b0, c3w3_s7[k]})
					: $signed({2'b0, c3w3_s7[k]})));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wm_s1 <= mag32(freq.omega);
			wn_s1 <= freq.omega[31];

			ww_s2 <= wm_s1 * wm_s1;
			wm_s2 <= wm_s1;
			wn_s2 <= wn_s1;

			w2_s3 <= 47'((ww_s2 + 64'd32768) >> 16);
			wm_s3 <= wm_s2;
			wn_s3 <= wn_s2;

			w3l_s4 <= w2_s3[31:0] * wm_s3;
			w3h_s4 <= w2_s3[46:32] * wm_s3;
			wn_s4  <= wn_s3;

			w3_s5 <= w3_sum[77:16];
			wn_s5 <= wn_s4;

			wn_s6 <= wn_s5;
			wn_s7 <= wn_s6;

			for (int k = 0; k < 2; k++) begin
				cw1_s2[k]  <= cm[k][1] * wm_s1;
				c1w_s3[k]  <= 47'((cw1_s2[k] + 64'd32768) >> 16);
				c2l_s4[k]  <= cm[k][2] * w2_s3[31:0];
				c2h_s4[k]  <= cm[k][2] * w2_s3[46:32];
				c1w_s4[k]  <= c1w_s3[k];
				c2w2_s5[k] <= c2_sum[k][77:16];
				c1w_s5[k]  <= c1w_s4[k];
				re_s6[k]   <= re_nxt[k];
				c3l_s6[k]  <= cm[k][3] * w3_s5[31:0];
				c3h_s6[k]  <= cm[k][3] * w3_s5[61:32];
				c1w_s6[k]  <= c1w_s5[k];
				c3w3_s7[k] <= c3_sat[k];
				re_s7[k]   <= re_s6[k];
				c1w_s7[k]  <= c1w_s6[k];
				re_s8[k]   <= re_s7[k];
				im_s8[k]   <= im_nxt[k];
			end

			pm_s9[0] <= re_s8[0][63] ? 62'(-re_s8[0]) : re_s8[0][61:0];
			pm_s9[1] <= im_s8[0][63] ? 62'(-im_s8[0]) : im_s8[0][61:0];
			pm_s9[2] <= re_s8[1][63] ? 62'(-re_s8[1]) : re_s8[1][61:0];
			pm_s9[3] <= im_s8[1][63] ? 62'(-im_s8[1]) : im_s8[1][61:0];
			pn_s9    <= {im_s8[1][63], re_s8[1][63], im_s8[0][63], re_s8[0][63]};
			fl_s9    <= '{dz: (re_s8[1] == '0) && (im_s8[1] == '0),
				nneg: {im_s8[0][63], re_s8[0][63]}, neg: 2'b00, ovf: 2'b00};

			for (int j = 0; j < 6; j++) begin
				ll_s10[j]   <= pm_s9[PROD_A[j]][31:0] * pm_s9[PROD_B[j]][31:0];
				lh_s10[j]   <= pm_s9[PROD_A[j]][31:0] * pm_s9[PROD_B[j]][61:32];
				hl_s10[j]   <= pm_s9[PROD_A[j]][61:32] * pm_s9[PROD_B[j]][31:0];
				hh_s10[j]   <= pm_s9[PROD_A[j]][61:32] * pm_s9[PROD_B[j]][61:32];
				pneg_s10[j] <= pn_s9[PROD_A[j]] ^ pn_s9[PROD_B[j]];
				pr_s11[j]   <= {hh_s10[j], 64'h0} + {30'h0, lh_s10[j], 32'h0}
					+ {30'h0, hl_s10[j], 32'h0} + {60'h0, ll_s10[j]};
			end
			fl_s10   <= fl_s9;
			pneg_s11 <= pneg_s10;
			fl_s11   <= fl_s10;

			for (int j = 0; j < 4; j++)
				sp_s12[j] <= pneg_s11[j] ? -$signed({2'b0, pr_s11[j]}) : $signed({2'b0, pr_s11[j]});
			dd_s12 <= {1'b0, pr_s11[4]} + {1'b0, pr_s11[5]};
			fl_s12 <= fl_s11;

			nu_s13[0] <= sp_s12[0] + sp_s12[1];
			nu_s13[1] <= sp_s12[2] - sp_s12[3];
			dd_s13    <= dd_s12;
			fl_s13    <= fl_s12;

			for (int c = 0; c < 2; c++)
				nm_s14[c] <= nu_s13[c][125] ? 125'(-nu_s13[c]) : nu_s13[c][124:0];
			dd_s14 <= dd_s13;
			fl_s14 <= '{dz: fl_s13.dz, nneg: fl_s13.nneg,
				neg: {nu_s13[1][125], nu_s13[0][125]}, ovf: 2'b00};

			for (int c = 0; c < 2; c++) begin
				dv_rem_s[0][c] <= {16'h0, nm_s14[c], 16'h0};
				dv_q_s[0][c]   <= '0;
			end
			dv_dd_s[0] <= dd_s14;
			dv_fl_s[0] <= '{dz: fl_s14.dz, nneg: fl_s14.nneg, neg: fl_s14.neg,
				ovf: {({16'h0, nm_s14[1]} >= {dd_s14, 16'h0}),
					({16'h0, nm_s14[0]} >= {dd_s14, 16'h0})}};

			out_re_q <= res_nxt[0];
			out_im_q <= res_nxt[1];
			out_dz_q <= dv_fl_s[DIV_STEPS].dz;
		end
	end

	for (genvar d = 1; d <= DIV_STEPS; d++) begin : g_div
		localparam int BIT = DIV_STEPS - d;
		logic [156:0] sh;
		assign sh = {32'h0, dv_dd_s[d-1]} << BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 2; c++) begin
					if (dv_rem_s[d-1][c] >= sh) begin
						dv_rem_s[d][c] <= dv_rem_s[d-1][c] - sh;
						dv_q_s[d][c]   <= dv_q_s[d-1][c] | (32'd1 << BIT);
					end else begin
						dv_rem_s[d][c] <= dv_rem_s[d-1][c];
						dv_q_s[d][c]   <= dv_q_s[d-1][c];
					end
				end
				dv_dd_s[d] <= dv_dd_s[d-1];
				dv_fl_s[d] <= dv_fl_s[d-1];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			if (dv_fl_s[DIV_STEPS].dz)
				res_nxt[c] = dv_fl_s[DIV_STEPS].nneg[c] ? NEG_FS : POS_FS;
			else if (dv_fl_s[DIV_STEPS].neg[c])
				res_nxt[c] = (dv_fl_s[DIV_STEPS].ovf[c]
					|| (dv_q_s[DIV_STEPS][c][31] && |dv_q_s[DIV_STEPS][c][30:0]))
					? NEG_FS : 32'(-dv_q_s[DIV_STEPS][c]);
			else
				res_nxt[c] = (dv_fl_s[DIV_STEPS].ovf[c] || dv_q_s[DIV_STEPS][c][31])
					? POS_FS : dv_q_s[DIV_STEPS][c];
		end
	end

	assign resp.valid          = vld_s[LAST];
	assign resp.response_real  = out_re_q;
	assign resp.response_imag  = out_im_q;
	assign resp.divide_by_zero = out_dz_q;

	a_dz_fullscale: assert property (@(posedge clk) disable iff (!arst_n)
		resp.valid && resp.divide_by_zero |->
			(out_re_q == POS_FS || out_re_q == NEG_FS) && (out_im_q == POS_FS || out_im_q == NEG_FS))
		else $error("zero denominator without full-scale result");

	a_dd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[14] && dd_s14 == '0 |-> fl_s14.dz)
		else $error("zero |D|^2 not flagged");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved while stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		freq.valid && freq.ready |=> vld_s[1])
		else $error("accepted transfer lost at entry");

endmodule
